### hw/rtl/bup_pkg.sv
// Shared types, constants and arithmetic helpers of the x8 bilinear upscaler.
// No dependencies; bup_ctrl, bup_dp, the top level and the testbench refer to this package.
`timescale 1ns / 1ps

package bup_pkg;

	// Default frame geometry
	localparam int DEF_SOURCE_WIDTH  = 32;
	localparam int DEF_SOURCE_HEIGHT = 32;

	// Fixed-point format of the source position
	localparam int FRAC_BITS = 10;
	localparam logic [10:0] FRAC_ONE = 11'd1024;

	// Centre-aligned mapping: pos = dst * 128 + 64 - 512, clamped at zero
	localparam int          UP_SHIFT   = 7;
	localparam logic [7:0]  DST_MIN    = 8'd4;
	localparam logic [14:0] POS_OFFSET = 15'd448;

	// Register reset value
	localparam logic [15:0] OUT_MAX_RESET = 16'd179;

	// Command field codes
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// Neighbor fetch order
	localparam logic [1:0] NBR_LL = 2'd0;  // x0, y0
	localparam logic [1:0] NBR_HL = 2'd1;  // x1, y0
	localparam logic [1:0] NBR_LH = 2'd2;  // x0, y1
	localparam logic [1:0] NBR_HH = 2'd3;  // x1, y1

	// One mapped axis: neighbor pair and 10-bit fraction
	typedef struct packed {
		logic [7:0] lo;
		logic [7:0] hi;
		logic [9:0] frac;
	} axis_t;

	// Controller to datapath commands
	typedef struct packed {
		logic       take;    // request accepted this cycle
		logic       rd_en;   // issue a frame read
		logic [1:0] nbr;     // which neighbor to read
		logic       cap_lo;  // capture read data as low operand
		logic       ld_v0;   // top row interpolation into v0
		logic       ld_v1;   // bottom row interpolation into v1
		logic       ld_out;  // vertical interpolation into output register
	} ctl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic out_stall;  // output register full and not taken
	} dp_stat_t;

	// Map a fine-grid coordinate onto a source axis whose last index is last
	function automatic axis_t map_axis(input logic [7:0] dst, input logic [7:0] last);
		logic [14:0] pos;
		logic [7:0]  i0;
		logic [9:0]  fr;
		axis_t       a;
		pos = (dst >= DST_MIN) ? ((15'(dst) << UP_SHIFT) - POS_OFFSET) : 15'd0;
		i0  = {3'b000, pos[14:FRAC_BITS]};
		fr  = pos[FRAC_BITS-1:0];
		// beyond the frame: pin to the edge, no fraction
		if (i0 > last) begin
			i0 = last;
			fr = '0;
		end
		a.lo   = i0;
		a.hi   = (i0 < last) ? (i0 + 8'd1) : last;
		a.frac = fr;
		return a;
	endfunction

	// (a * (1024 - f) + b * f) / 1024, truncated
	function automatic logic [15:0] lerp(input logic [15:0] a, input logic [15:0] b,
			input logic [9:0] f);
		logic [26:0] s;
		s = 27'(a) * 27'(FRAC_ONE - {1'b0, f}) + 27'(b) * 27'(f);
		return s[25:10];
	endfunction

endpackage

### hw/rtl/bup_if.sv
// Valid/ready channel interfaces of the x8 bilinear upscaler.
// Depends on nothing; used by the top level and the datapath.
`timescale 1ns / 1ps

// Request channel: pixel loads and interpolation queries
interface bup_req_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [4:0]  pixel_col;
	logic [4:0]  pixel_row;
	logic [15:0] pixel_value;
	logic [7:0]  dst_x;
	logic [7:0]  dst_y;

	modport source (output valid, command, pixel_col, pixel_row, pixel_value, dst_x, dst_y,
		input ready);
	modport sink (input valid, command, pixel_col, pixel_row, pixel_value, dst_x, dst_y,
		output ready);
endinterface

// Result channel: one interpolated value per query
interface bup_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] interpolated;

	modport source (output valid, interpolated, input ready);
	modport sink (input valid, interpolated, output ready);
endinterface

### hw/rtl/bup_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module bup_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### hw/rtl/bup_ctrl.sv
// Controller of the x8 bilinear upscaler: sequences reads and interpolation steps.
// Depends on bup_pkg.
`timescale 1ns / 1ps

module bup_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_command,
	output logic              req_ready,
	input  bup_pkg::dp_stat_t stat,
	output bup_pkg::ctl_cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_READ = 4'b0010,
		ST_LAST = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	state_t     state_q, state_nx;
	logic [1:0] nbr_q;
	logic       take;

	assign req_ready = (state_q == ST_IDLE);
	assign take      = req_valid && req_ready;

	// Next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (take && req_command == bup_pkg::CMD_QUERY) begin
					state_nx = ST_READ;
				end
			end
			ST_READ: begin
				if (nbr_q == bup_pkg::NBR_HH) begin
					state_nx = ST_LAST;
				end
			end
			ST_LAST: state_nx = ST_FIN;
			ST_FIN: begin
				if (!stat.out_stall) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// State and neighbor counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			nbr_q   <= bup_pkg::NBR_LL;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_READ) begin
				nbr_q <= nbr_q + 2'd1;
			end else begin
				nbr_q <= bup_pkg::NBR_LL;
			end
		end
	end

	// Commands: read data comes back in the cycle after its address
	always_comb begin
		cmd        = '0;
		cmd.take   = take;
		cmd.nbr    = nbr_q;
		cmd.rd_en  = (state_q == ST_READ);
		cmd.cap_lo = (state_q == ST_READ) &&
			(nbr_q == bup_pkg::NBR_HL || nbr_q == bup_pkg::NBR_HH);
		cmd.ld_v0  = (state_q == ST_READ) && (nbr_q == bup_pkg::NBR_LH);
		cmd.ld_v1  = (state_q == ST_LAST);
		cmd.ld_out = (state_q == ST_FIN) && !stat.out_stall;
	end

endmodule

### hw/rtl/bup_dp.sv
// Datapath of the x8 bilinear upscaler: frame store, axis mapping, shared
// interpolation unit, clamp and output register. Depends on bup_pkg, bup_if, bup_ram.
`timescale 1ns / 1ps

module bup_dp #(
	parameter int SOURCE_WIDTH  = bup_pkg::DEF_SOURCE_WIDTH,
	parameter int SOURCE_HEIGHT = bup_pkg::DEF_SOURCE_HEIGHT
) (
	input  logic              clk,
	input  logic              arst_n,
	bup_req_if.sink           req,
	bup_rsp_if.source         rsp,
	input  logic              cfg_wr_en,
	input  logic [15:0]       cfg_wr_data,
	input  bup_pkg::ctl_cmd_t cmd,
	output bup_pkg::dp_stat_t stat
);

	localparam int DEPTH = SOURCE_WIDTH * SOURCE_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int XW    = $clog2(SOURCE_WIDTH);
	localparam int YW    = $clog2(SOURCE_HEIGHT);
	localparam logic [8:0] W_LIM  = 9'(SOURCE_WIDTH);
	localparam logic [8:0] H_LIM  = 9'(SOURCE_HEIGHT);
	localparam logic [7:0] X_LAST = 8'(SOURCE_WIDTH - 1);
	localparam logic [7:0] Y_LAST = 8'(SOURCE_HEIGHT - 1);
	localparam logic [AW-1:0] H_STRIDE = AW'(SOURCE_HEIGHT);

	bup_pkg::axis_t ax, ay;
	logic [XW-1:0]  x_lo_q, x_hi_q;
	logic [YW-1:0]  y_lo_q, y_hi_q;
	logic [9:0]     fx_q, fy_q;
	logic [15:0]    out_max_q;
	logic [15:0]    v_lo_q, v0_q, v1_q;
	logic [15:0]    rdata;
	logic [15:0]    lerp_a, lerp_b, lerp_r, clamped;
	logic [9:0]     lerp_f;
	logic [XW-1:0]  rd_col;
	logic [YW-1:0]  rd_row;
	logic [AW-1:0]  raddr, waddr;
	logic           we;
	logic           rsp_valid_q;
	logic [15:0]    rsp_data_q;

	// Output-max register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_max_q <= bup_pkg::OUT_MAX_RESET;
		end else if (cfg_wr_en) begin
			out_max_q <= cfg_wr_data;
		end
	end

	// Load: write straight into the frame store if inside the frame
	assign we = cmd.take && (req.command == bup_pkg::CMD_LOAD) &&
		({4'b0000, req.pixel_col} < W_LIM) && ({4'b0000, req.pixel_row} < H_LIM);
	assign waddr = AW'(XW'(req.pixel_col)) * H_STRIDE + AW'(YW'(req.pixel_row));

	// Query: map both axes and hold the neighbors
	assign ax = bup_pkg::map_axis(req.dst_x, X_LAST);
	assign ay = bup_pkg::map_axis(req.dst_y, Y_LAST);

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			x_lo_q <= ax.lo[XW-1:0];
			x_hi_q <= ax.hi[XW-1:0];
			fx_q   <= ax.frac;
			y_lo_q <= ay.lo[YW-1:0];
			y_hi_q <= ay.hi[YW-1:0];
			fy_q   <= ay.frac;
		end
	end

	// Neighbor read address
	always_comb begin
		unique case (cmd.nbr)
			bup_pkg::NBR_LL: begin rd_col = x_lo_q; rd_row = y_lo_q; end
			bup_pkg::NBR_HL: begin rd_col = x_hi_q; rd_row = y_lo_q; end
			bup_pkg::NBR_LH: begin rd_col = x_lo_q; rd_row = y_hi_q; end
			bup_pkg::NBR_HH: begin rd_col = x_hi_q; rd_row = y_hi_q; end
			default:         begin rd_col = x_lo_q; rd_row = y_lo_q; end
		endcase
	end
	assign raddr = AW'(rd_col) * H_STRIDE + AW'(rd_row);

	bup_ram #(
		.WIDTH(16),
		.DEPTH(DEPTH)
	) u_frame (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(req.pixel_value),
		.re   (cmd.rd_en),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Shared interpolation unit: rows along x, then the final step along y
	always_comb begin
		if (cmd.ld_out) begin
			lerp_a = v0_q;
			lerp_b = v1_q;
			lerp_f = fy_q;
		end else begin
			lerp_a = v_lo_q;
			lerp_b = rdata;
			lerp_f = fx_q;
		end
		lerp_r  = bup_pkg::lerp(lerp_a, lerp_b, lerp_f);
		clamped = (lerp_r > out_max_q) ? out_max_q : lerp_r;
	end

	// Operand and row result registers
	always_ff @(posedge clk) begin
		if (cmd.cap_lo) begin
			v_lo_q <= rdata;
		end
		if (cmd.ld_v0) begin
			v0_q <= lerp_r;
		end
		if (cmd.ld_v1) begin
			v1_q <= lerp_r;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.ld_out) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_out) begin
			rsp_data_q <= clamped;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.interpolated = rsp_data_q;
	assign stat.out_stall   = rsp_valid_q && !rsp.ready;

endmodule

### hw/rtl/bilinear_upscale_x8_top.sv
// Top level of the x8 bilinear upscaler: controller plus datapath.
// Depends on bup_pkg, bup_if, bup_ram, bup_ctrl, bup_dp.
//
//  channel | dir | handshake           | payload
//  req     | in  | valid / ready       | command, pixel_col, pixel_row, pixel_value, dst_x, dst_y
//  rsp     | out | valid / ready       | interpolated
//  cfg     | in  | cfg_wr_en           | cfg_wr_data (output_max)
//
// A load is written into the frame memory at the edge it is accepted.
// A query runs from acceptance to result as follows, and the next request is taken after it:
// four neighbor reads through the single frame memory read port, then two more steps.
// The result sits in an output register; a new request is taken while it waits, and
// a following query stalls in its last step only if that register is still full.
// Reset clears control and sets output_max to 179; the frame memory is not cleared.
`timescale 1ns / 1ps

module bilinear_upscale_x8_top #(
	parameter int SOURCE_WIDTH  = bup_pkg::DEF_SOURCE_WIDTH,
	parameter int SOURCE_HEIGHT = bup_pkg::DEF_SOURCE_HEIGHT
) (
	input  logic        clk,
	input  logic        arst_n,
	bup_req_if.sink     req,
	bup_rsp_if.source   rsp,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data
);

	bup_pkg::ctl_cmd_t cmd;
	bup_pkg::dp_stat_t stat;

	bup_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_command(req.command),
		.req_ready  (req.ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	bup_dp #(
		.SOURCE_WIDTH (SOURCE_WIDTH),
		.SOURCE_HEIGHT(SOURCE_HEIGHT)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.cmd        (cmd),
		.stat       (stat)
	);

endmodule

### tb/testbench.sv
// Self-checking testbench of the x8 bilinear upscaler: pixel loads and interpolation
// queries go in over the request channel; results are checked against a local predictor.
// Depends on bup_pkg, bup_if and the RTL under hw/rtl.
`timescale 1ns / 1ps

module testbench;

	localparam int CLK_PERIOD     = 8;
	localparam int FRAME_W        = bup_pkg::DEF_SOURCE_WIDTH;
	localparam int FRAME_H        = bup_pkg::DEF_SOURCE_HEIGHT;
	localparam int FRAME_DEPTH    = FRAME_W * FRAME_H;
	localparam int FIX_ONE        = 1024;
	localparam int FIX_HALF       = 512;
	localparam int UPSCALE        = 8;
	localparam int SETTLE_CYCLES  = 16;
	localparam int HOLD_CYCLES    = 300;
	localparam int HALF_ITEMS     = 333;
	localparam int TIMEOUT_CYCLES = 400000;

	// One request as the sender sees it
	typedef struct {
		logic        command;
		logic [4:0]  col;
		logic [4:0]  row;
		logic [15:0] value;
		logic [7:0]  dx;
		logic [7:0]  dy;
	} pix_req_t;

	// Neighbor pair and fraction along one axis
	typedef struct {
		int unsigned lo;
		int unsigned hi;
		int unsigned frac;
	} span_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [15:0] cfg_wr_data;

	bup_req_if req_ch ();
	bup_rsp_if rsp_ch ();

	bilinear_upscale_x8_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	// Stimulus and prediction state
	pix_req_t    pending_reqs[$];
	logic [15:0] interp_due[$];
	logic [15:0] frame_mirror[FRAME_DEPTH];
	logic [15:0] clamp_mirror = bup_pkg::OUT_MAX_RESET;
	bit          loaded_map[FRAME_DEPTH];
	int          queued_count = 0;
	int          err_count = 0;
	int          send_idle_pct = 19;
	int          recv_idle_pct = 72;
	bit          hold_go = 1'b0;
	bit          hold_taken;
	int          hold_left;

	// Clock
	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Reset, with every block input at a known value from time zero
	initial begin
		arst_n       = 1'b0;
		cfg_wr_en    = 1'b0;
		cfg_wr_data  = '0;
		req_ch.valid = 1'b0;
		req_ch.command     = bup_pkg::CMD_LOAD;
		req_ch.pixel_col   = '0;
		req_ch.pixel_row   = '0;
		req_ch.pixel_value = '0;
		req_ch.dst_x = '0;
		req_ch.dst_y = '0;
		rsp_ch.ready = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Fine-grid coordinate to source neighbors, centre aligned, clamped at both ends
	function automatic span_t src_span(input logic [7:0] dst, input int unsigned len);
		int unsigned scaled;
		int unsigned pos;
		span_t       s;
		scaled = (32'(dst) * FIX_ONE + FIX_HALF) / UPSCALE;
		pos    = (scaled >= FIX_HALF) ? scaled - FIX_HALF : 0;
		s.lo   = pos / FIX_ONE;
		s.frac = pos % FIX_ONE;
		if (s.lo > len - 1) begin
			s.lo   = len - 1;
			s.frac = 0;
		end
		s.hi = (s.lo + 1 > len - 1) ? len - 1 : s.lo + 1;
		return s;
	endfunction

	// Expected value of a query: x pass, then y pass, truncating, then clamp
	function automatic logic [15:0] interp_expected(input logic [7:0] dx, input logic [7:0] dy);
		span_t           sx;
		span_t           sy;
		longint unsigned v00, v01, v10, v11, upper, lower, res;
		sx = src_span(dx, FRAME_W);
		sy = src_span(dy, FRAME_H);
		v00 = frame_mirror[sx.lo * FRAME_H + sy.lo];
		v01 = frame_mirror[sx.hi * FRAME_H + sy.lo];
		v10 = frame_mirror[sx.lo * FRAME_H + sy.hi];
		v11 = frame_mirror[sx.hi * FRAME_H + sy.hi];
		upper = (v00 * (FIX_ONE - sx.frac) + v01 * sx.frac) / FIX_ONE;
		lower = (v10 * (FIX_ONE - sx.frac) + v11 * sx.frac) / FIX_ONE;
		res   = (upper * (FIX_ONE - sy.frac) + lower * sy.frac) / FIX_ONE;
		if (res > clamp_mirror)
			res = clamp_mirror;
		return res[15:0];
	endfunction

	// Pixel values: extremes, small values, and full range
	function automatic logic [15:0] rand_pixel();
		case ($urandom_range(7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2, 3: return 16'($urandom_range(255));
			4: return 16'($urandom_range(1023));
			default: return 16'($urandom);
		endcase
	endfunction

	// Destination coordinates, leaning on both frame edges
	function automatic logic [7:0] pick_dst();
		int k;
		if ($urandom_range(7) == 0) begin
			k = $urandom_range(9);
			return (k < 5) ? 8'(k) : 8'(246 + k);
		end
		return 8'($urandom_range(255));
	endfunction

	task automatic push_load(input int col, input int row, input logic [15:0] value);
		pix_req_t r;
		r.command = bup_pkg::CMD_LOAD;
		r.col     = 5'(col);
		r.row     = 5'(row);
		r.value   = value;
		r.dx      = 8'($urandom);
		r.dy      = 8'($urandom);
		pending_reqs.push_back(r);
		loaded_map[col * FRAME_H + row] = 1'b1;
		queued_count++;
	endtask

	// A query, preceded by loads of any neighbor that was never written
	task automatic push_query(input logic [7:0] dx, input logic [7:0] dy);
		span_t    sx;
		span_t    sy;
		int       cols[2];
		int       rows[2];
		pix_req_t r;
		sx = src_span(dx, FRAME_W);
		sy = src_span(dy, FRAME_H);
		cols = '{sx.lo, sx.hi};
		rows = '{sy.lo, sy.hi};
		foreach (cols[i])
			foreach (rows[j])
				if (!loaded_map[cols[i] * FRAME_H + rows[j]])
					push_load(cols[i], rows[j], rand_pixel());
		r.command = bup_pkg::CMD_QUERY;
		r.col     = 5'($urandom);
		r.row     = 5'($urandom);
		r.value   = 16'($urandom);
		r.dx      = dx;
		r.dy      = dy;
		pending_reqs.push_back(r);
		queued_count++;
	endtask

	// Mostly queries on random points, with stray loads overwriting the frame
	task automatic push_random(input int count);
		int target;
		target = queued_count + count;
		while (queued_count < target) begin
			if ($urandom_range(99) < 70)
				push_query(pick_dst(), pick_dst());
			else
				push_load($urandom_range(FRAME_W - 1), $urandom_range(FRAME_H - 1), rand_pixel());
		end
	endtask

	// Sender pause: nothing queued, nothing in flight, nothing owed
	task automatic wait_drained();
		while (pending_reqs.size() != 0 || req_ch.valid || interp_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_out_max(input logic [15:0] value);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en    <= 1'b0;
		clamp_mirror = value;
		@(negedge clk);
	endtask

	// Request driver; updates the predictor on every accepted request
	always @(posedge clk or negedge arst_n) begin : drive_req
		pix_req_t nxt;
		if (!arst_n) begin
			req_ch.valid       <= 1'b0;
			req_ch.command     <= bup_pkg::CMD_LOAD;
			req_ch.pixel_col   <= '0;
			req_ch.pixel_row   <= '0;
			req_ch.pixel_value <= '0;
			req_ch.dst_x       <= '0;
			req_ch.dst_y       <= '0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				if (req_ch.command == bup_pkg::CMD_LOAD)
					frame_mirror[req_ch.pixel_col * FRAME_H + req_ch.pixel_row] = req_ch.pixel_value;
				else
					interp_due.push_back(interp_expected(req_ch.dst_x, req_ch.dst_y));
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = pending_reqs.pop_front();
					req_ch.valid       <= 1'b1;
					req_ch.command     <= nxt.command;
					req_ch.pixel_col   <= nxt.col;
					req_ch.pixel_row   <= nxt.row;
					req_ch.pixel_value <= nxt.value;
					req_ch.dst_x       <= nxt.dx;
					req_ch.dst_y       <= nxt.dy;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and receiver backpressure, with one long hold-off on request
	always @(posedge clk or negedge arst_n) begin : watch_rsp
		logic [15:0] want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			hold_taken   <= 1'b0;
			hold_left    <= 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (interp_due.size() == 0) begin
					$error("interpolated: unexpected result, actual %0d", rsp_ch.interpolated);
					err_count++;
				end else begin
					want = interp_due.pop_front();
					if (rsp_ch.interpolated !== want) begin
						$error("interpolated mismatch: expected %0d, actual %0d",
							want, rsp_ch.interpolated);
						err_count++;
					end
				end
			end
			if (hold_go && !hold_taken) begin
				hold_taken   <= 1'b1;
				hold_left    <= HOLD_CYCLES;
				rsp_ch.ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left    <= hold_left - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Stimulus sequence
	initial begin : stimulus
		logic [15:0] clamp_plan[6];
		int          send_plan[3];
		int          recv_plan[3];
		clamp_plan = '{16'hFFFF, 16'($urandom_range(1, 65534)),
			16'h0000, 16'($urandom_range(1, 400)),
			16'($urandom_range(1, 65534)), 16'hFFFF};
		send_plan = '{19, 72, 0};
		recv_plan = '{72, 19, 0};
		@(posedge arst_n);
		@(negedge clk);

		// Directed: corner pixels, mostly at the value extremes, queries at both edges
		push_load(0, 0, 16'hFFFF);
		push_load(1, 0, 16'h0000);
		push_load(0, 1, 16'h0000);
		push_load(1, 1, 16'hFFFF);
		push_load(FRAME_W - 1, FRAME_H - 1, 16'hFFFF);
		push_load(FRAME_W - 2, FRAME_H - 1, 16'h0000);
		push_load(FRAME_W - 1, FRAME_H - 2, 16'h0000);
		push_load(FRAME_W - 2, FRAME_H - 2, 16'd12345);
		push_query(8'd0, 8'd0);      // negative position on both axes
		push_query(8'd3, 8'd0);
		push_query(8'd4, 8'd4);      // first point at or past zero
		push_query(8'd5, 8'd11);
		push_query(8'd11, 8'd11);
		push_query(8'd255, 8'd255);  // last column and row, high neighbor pinned
		push_query(8'd252, 8'd244);
		push_query(8'd244, 8'd255);
		push_query(8'd250, 8'd250);
		push_query(8'd0, 8'd255);
		wait_drained();

		// Random phases; each half gets its own clamp, the gap between them drains all
		for (int p = 0; p < 3; p++) begin
			send_idle_pct = send_plan[p];
			recv_idle_pct = recv_plan[p];
			for (int h = 0; h < 2; h++) begin
				write_out_max(clamp_plan[2 * p + h]);
				if (p == 2 && h == 1)
					hold_go = 1'b1;
				push_random(HALF_ITEMS);
				wait_drained();
			end
		end

		if (err_count == 0 && interp_due.size() == 0)
			$display("[bilinear_upscale_x8_top] OK");
		else
			$display("[bilinear_upscale_x8_top] ERROR");
		$finish;
	end

	// Watchdog
	initial begin
		#(longint'(TIMEOUT_CYCLES) * CLK_PERIOD);
		$display("[bilinear_upscale_x8_top] ERROR");
		$finish;
	end

endmodule
